/* rtl/core/mbrm_pkg.sv */
// ----------------------------------------------------------------------------
// mbrm_pkg
// Shared types and constants of the Modbus RTU register master: the command
// word passed from the request/reply front end to the result sequencer.
// ----------------------------------------------------------------------------
package mbrm_pkg;

  // Completion report codes.
  typedef enum logic [1:0] {
    StatusOk   = 2'd0,
    StatusFail = 2'd1,
    StatusBusy = 2'd2
  } status_e;

  // Input word actions.
  typedef enum logic [1:0] {
    ActWrite   = 2'd0,
    ActRead    = 2'd1,
    ActRxByte  = 2'd2,
    ActTimeout = 2'd3
  } action_e;

  // Configuration register indexes.
  localparam logic [0:0] CfgSlaveId     = 1'b0;
  localparam logic [0:0] CfgMaxAttempts = 1'b1;

  // Modbus function codes and CRC-16/MODBUS constants.
  localparam logic [7:0]  FuncWrite = 8'h06;
  localparam logic [7:0]  FuncRead  = 8'h03;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;

  // Result kinds.
  localparam logic KindTx     = 1'b0;
  localparam logic KindReport = 1'b1;

  localparam int unsigned FrameBytes = 8;

  // Byte 0 of the frame is sent first.
  typedef logic [FrameBytes-1:0][7:0] frame_t;

  // One command for the sequencer: either a report or a full frame to send.
  typedef struct packed {
    logic        is_report;
    status_e     status;
    logic [15:0] value;
    frame_t      frame;
  } cmd_t;

endpackage

/* rtl/core/mbrm_front.sv */
// ----------------------------------------------------------------------------
// mbrm_front
// Accepts requests, reply bytes and timeouts, builds the request frame with
// its CRC, judges replies and issues send or report commands to the queue.
// ----------------------------------------------------------------------------
module mbrm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [15:0]          reg_address_i,
  input  logic [15:0]          reg_value_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 frame_end_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 full_i,
  output logic                 push_o,
  output mbrm_pkg::cmd_t       push_cmd_o
);

  typedef enum logic [1:0] {
    OpIdle  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2
  } op_e;

  localparam logic [2:0]  CrcLastIdx = 3'd6;

  // One byte of CRC-16/MODBUS, LSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ mbrm_pkg::CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  op_e              pending_q, pending_d;
  logic [2:0]       attempts_q, attempts_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             mm_q, mm_d;
  logic [15:0]      cap_q, cap_d;
  mbrm_pkg::frame_t frame_q, frame_d;
  logic             crc_busy_q, crc_busy_d;
  logic [2:0]       crc_idx_q, crc_idx_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       slave_id_q, slave_id_d;
  logic [2:0]       max_att_q, max_att_d;

  logic              accept;
  mbrm_pkg::action_e action;
  logic              byte_mm;
  logic [15:0]       byte_cap;
  logic [3:0]        byte_cnt;

  assign in_ready_o = !crc_busy_q && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign action     = mbrm_pkg::action_e'(action_i);

  // Judge one reply byte against the frame being served.
  always_comb begin
    byte_mm  = mm_q;
    byte_cap = cap_q;
    if (pending_q == OpWrite) begin
      if (cnt_q >= 4'd8 || rx_byte_i != frame_q[cnt_q[2:0]]) begin
        byte_mm = 1'b1;
      end
    end else begin
      if (cnt_q == 4'd0 && rx_byte_i != frame_q[0]) begin
        byte_mm = 1'b1;
      end else if (cnt_q == 4'd1 && rx_byte_i != mbrm_pkg::FuncRead) begin
        byte_mm = 1'b1;
      end else if (cnt_q == 4'd3) begin
        byte_cap[15:8] = rx_byte_i;
      end else if (cnt_q == 4'd4) begin
        byte_cap[7:0] = rx_byte_i;
      end else if (cnt_q >= 4'd7) begin
        byte_mm = 1'b1;
      end
    end
    byte_cnt = (cnt_q != 4'd15) ? cnt_q + 4'd1 : cnt_q;
  end

  always_comb begin
    pending_d  = pending_q;
    attempts_d = attempts_q;
    cnt_d      = cnt_q;
    mm_d       = mm_q;
    cap_d      = cap_q;
    frame_d    = frame_q;
    crc_busy_d = crc_busy_q;
    crc_idx_d  = crc_idx_q;
    crc_d      = crc_q;
    slave_id_d = slave_id_q;
    max_att_d  = max_att_q;
    push_o     = 1'b0;
    push_cmd_o = '{is_report: 1'b0, status: mbrm_pkg::StatusOk, value: 16'h0000,
                   frame: frame_q};

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mbrm_pkg::CfgSlaveId:     slave_id_d = cfg_data_i;
        mbrm_pkg::CfgMaxAttempts: max_att_d  = cfg_data_i[2:0];
        default:                  ;
      endcase
    end

    if (crc_busy_q) begin
      if (crc_idx_q != CrcLastIdx) begin
        crc_d     = crc_byte(crc_q, frame_q[crc_idx_q]);
        crc_idx_d = crc_idx_q + 3'd1;
      end else if (!full_i) begin
        frame_d[6]       = crc_q[7:0];
        frame_d[7]       = crc_q[15:8];
        push_o           = 1'b1;
        push_cmd_o.frame = frame_d;
        crc_busy_d       = 1'b0;
      end
    end else if (accept) begin
      if (action == mbrm_pkg::ActWrite || action == mbrm_pkg::ActRead) begin
        if (pending_q != OpIdle) begin
          push_o               = 1'b1;
          push_cmd_o.is_report = 1'b1;
          push_cmd_o.status    = mbrm_pkg::StatusBusy;
        end else begin
          frame_d[0] = slave_id_q;
          frame_d[1] = (action == mbrm_pkg::ActWrite) ? mbrm_pkg::FuncWrite
                                                      : mbrm_pkg::FuncRead;
          frame_d[2] = reg_address_i[15:8];
          frame_d[3] = reg_address_i[7:0];
          frame_d[4] = (action == mbrm_pkg::ActWrite) ? reg_value_i[15:8] : 8'h00;
          frame_d[5] = (action == mbrm_pkg::ActWrite) ? reg_value_i[7:0] : 8'h01;
          pending_d  = (action == mbrm_pkg::ActWrite) ? OpWrite : OpRead;
          attempts_d = 3'd1;
          cnt_d      = 4'd0;
          mm_d       = 1'b0;
          cap_d      = 16'h0000;
          crc_d      = mbrm_pkg::CrcInit;
          crc_idx_d  = 3'd0;
          crc_busy_d = 1'b1;
        end
      end else if (pending_q != OpIdle) begin
        logic judge;
        logic good;
        judge = (action == mbrm_pkg::ActTimeout) || frame_end_i;
        good  = 1'b0;
        if (action == mbrm_pkg::ActRxByte) begin
          cnt_d = byte_cnt;
          mm_d  = byte_mm;
          cap_d = byte_cap;
          good  = !byte_mm && ((pending_q == OpWrite) ? (byte_cnt == 4'd8)
                                                      : (byte_cnt == 4'd7));
        end
        if (judge) begin
          cnt_d = 4'd0;
          mm_d  = 1'b0;
          cap_d = 16'h0000;
          push_o = 1'b1;
          if (good) begin
            pending_d            = OpIdle;
            push_cmd_o.is_report = 1'b1;
            push_cmd_o.status    = mbrm_pkg::StatusOk;
            push_cmd_o.value     = (pending_q == OpRead) ? byte_cap : 16'h0000;
          end else if (attempts_q < max_att_q) begin
            // Resend the stored frame.
            attempts_d = attempts_q + 3'd1;
          end else begin
            pending_d            = OpIdle;
            push_cmd_o.is_report = 1'b1;
            push_cmd_o.status    = mbrm_pkg::StatusFail;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= OpIdle;
      attempts_q <= 3'd0;
      cnt_q      <= 4'd0;
      mm_q       <= 1'b0;
      cap_q      <= 16'h0000;
      crc_busy_q <= 1'b0;
      crc_idx_q  <= 3'd0;
      crc_q      <= mbrm_pkg::CrcInit;
      slave_id_q <= 8'h01;
      max_att_q  <= 3'd3;
    end else begin
      pending_q  <= pending_d;
      attempts_q <= attempts_d;
      cnt_q      <= cnt_d;
      mm_q       <= mm_d;
      cap_q      <= cap_d;
      crc_busy_q <= crc_busy_d;
      crc_idx_q  <= crc_idx_d;
      crc_q      <= crc_d;
      slave_id_q <= slave_id_d;
      max_att_q  <= max_att_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  // A frame under CRC always belongs to a pending request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_busy_q |-> pending_q != OpIdle)
    else $error("CRC pass without a pending request");

  // Reply tracking is cleared whenever no request is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == OpIdle |-> cnt_q == 4'd0 && !mm_q)
    else $error("stale reply state while idle");

endmodule

/* rtl/core/mbrm_queue.sv */
// ----------------------------------------------------------------------------
// mbrm_queue
// Short command queue between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module mbrm_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mbrm_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output mbrm_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mbrm_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty command queue");

endmodule

/* rtl/core/mbrm_back.sv */
// ----------------------------------------------------------------------------
// mbrm_back
// Result sequencer: turns each queued command into one report word or eight
// transmit words, through a registered output stage.
// ----------------------------------------------------------------------------
module mbrm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  mbrm_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           kind_o,
  output logic [7:0]     tx_byte_o,
  output logic           last_byte_o,
  output logic [1:0]     status_o,
  output logic [15:0]    read_value_o
);

  localparam logic [2:0] LastIdx = 3'(mbrm_pkg::FrameBytes - 1);

  logic             active_q;
  logic [2:0]       idx_q;
  mbrm_pkg::frame_t frame_q;
  logic             out_valid_q;
  logic             kind_q;
  logic [7:0]       tx_q;
  logic             last_q;
  logic [1:0]       status_q;
  logic [15:0]      value_q;
  logic             load;

  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = load && !active_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= 3'd0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= mbrm_pkg::KindTx;
      tx_q        <= 8'h00;
      last_q      <= 1'b0;
      status_q    <= mbrm_pkg::StatusOk;
      value_q     <= 16'h0000;
    end else if (load) begin
      if (active_q) begin
        out_valid_q <= 1'b1;
        kind_q      <= mbrm_pkg::KindTx;
        tx_q        <= frame_q[idx_q];
        last_q      <= idx_q == LastIdx;
        status_q    <= mbrm_pkg::StatusOk;
        value_q     <= 16'h0000;
        idx_q       <= idx_q + 3'd1;
        if (idx_q == LastIdx) begin
          active_q <= 1'b0;
        end
      end else if (!empty_i) begin
        out_valid_q <= 1'b1;
        last_q      <= 1'b0;
        if (head_i.is_report) begin
          kind_q   <= mbrm_pkg::KindReport;
          tx_q     <= 8'h00;
          status_q <= head_i.status;
          value_q  <= head_i.value;
        end else begin
          // First byte goes out now; the rest follow from the local copy.
          kind_q   <= mbrm_pkg::KindTx;
          tx_q     <= head_i.frame[0];
          status_q <= mbrm_pkg::StatusOk;
          value_q  <= 16'h0000;
          frame_q  <= head_i.frame;
          idx_q    <= 3'd1;
          active_q <= 1'b1;
        end
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign tx_byte_o    = tx_q;
  assign last_byte_o  = last_q;
  assign status_o     = status_q;
  assign read_value_o = value_q;

  // The last-byte flag only ever marks a transmit word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> kind_q == mbrm_pkg::KindTx)
    else $error("last byte flag on a report");

  // A frame in progress never takes a new command.
  assert property (@(posedge clk_i) disable iff (!rst_ni) active_q |-> !pop_o)
    else $error("command popped while a frame is being sent");

endmodule

/* rtl/core/modbus_rtu_register_master_top.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_register_master_top
// Modbus RTU master for one holding register: frames write and read requests
// with CRC-16/MODBUS, checks replies and retries up to the attempt limit.
// ----------------------------------------------------------------------------
// A reply byte or timeout pushes any command it yields in the cycle it is taken.
// A request holds off the input while the CRC runs over the six header bytes,
// one byte per cycle, and until its frame is queued, which waits on a full queue.
// Throughput: one reply byte or timeout per cycle while the queue has room and
// no CRC runs, one output word per cycle while out_ready_i is high.
// Reset: asynchronous; slave id 1, three attempts.
module modbus_rtu_register_master_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] reg_address_i,
  input  logic [15:0] reg_value_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o,
  output logic [1:0]  status_o,
  output logic [15:0] read_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic           push;
  mbrm_pkg::cmd_t push_cmd;
  logic           pop;
  mbrm_pkg::cmd_t head;
  logic           full;
  logic           empty;

  assign cfg_ready_o = 1'b1;

  mbrm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .reg_address_i (reg_address_i),
    .reg_value_i   (reg_value_i),
    .rx_byte_i     (rx_byte_i),
    .frame_end_i   (frame_end_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .full_i        (full),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  mbrm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (full),
    .empty_o    (empty)
  );

  mbrm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .tx_byte_o    (tx_byte_o),
    .last_byte_o  (last_byte_o),
    .status_o     (status_o),
    .read_value_o (read_value_o)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus RTU register master. Request, reply-byte
// and timeout words are fed through the input handshake, and every accepted
// word runs through an in-bench model of the master to predict the frame bytes
// and completion reports. The monitor compares each output word with the
// oldest prediction. Both handshakes stall at random, and the slave id and the
// attempt limit are changed between traffic phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // Reset values of the configuration registers.
  localparam logic [7:0] ResetSlaveId   = 8'd1;
  localparam logic [2:0] ResetAttempts  = 3'd3;

  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned EndWaitLimit  = 20000;

  typedef enum logic [1:0] {
    OpIdle  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2
  } pend_op_e;

  typedef enum int unsigned {
    FaultNone,
    FaultTimeout,
    FaultCorrupt,
    FaultShort,
    FaultLong
  } fault_e;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    logic [7:0]  rx_byte;
    logic        frame_end;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        tx_byte;
    logic              last_byte;
    mbrm_pkg::status_e status;
    logic [15:0]       read_value;
  } out_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i      = mbrm_pkg::ActRxByte;
  logic [15:0] reg_address_i = 16'h0000;
  logic [15:0] reg_value_i   = 16'h0000;
  logic [7:0]  rx_byte_i     = 8'h00;
  logic        frame_end_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_byte_o;
  logic [1:0]  status_o;
  logic [15:0] read_value_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = mbrm_pkg::CfgSlaveId;
  logic [7:0]  cfg_data_i    = 8'h00;

  modbus_rtu_register_master_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .reg_address_i (reg_address_i),
    .reg_value_i   (reg_value_i),
    .rx_byte_i     (rx_byte_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .tx_byte_o     (tx_byte_o),
    .last_byte_o   (last_byte_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_word_t    input_words[$];
  out_word_t   expected_words[$];
  in_word_t    cur_word;
  out_word_t   want;
  int unsigned tx_idle_pct = 8;
  int unsigned rx_idle_pct = 69;
  int unsigned words_pushed;
  int unsigned noise_pushed;
  int unsigned words_taken;
  int unsigned quiet_cycles;
  int unsigned errors;
  int unsigned n_requests, n_rx_bytes, n_timeouts, n_reg_writes;
  int unsigned n_tx_words, n_ok, n_failed, n_busy;

  // Master state as the bench sees it, starting from the reset values.
  logic [7:0]       cfg_slave    = ResetSlaveId;
  logic [2:0]       cfg_attempts = ResetAttempts;
  pend_op_e         pend_op      = OpIdle;
  mbrm_pkg::frame_t pend_frame   = '0;
  logic [2:0]       tries        = 3'd0;
  logic [3:0]       rx_count     = 4'd0;
  logic             rx_bad       = 1'b0;
  logic [15:0]      rx_value     = 16'h0000;

  function automatic mbrm_pkg::frame_t build_frame(input logic [1:0] act,
                                                   input logic [15:0] addr,
                                                   input logic [15:0] val,
                                                   input logic [7:0] slave);
    mbrm_pkg::frame_t f;
    logic [15:0]      crc;
    f[0] = slave;
    f[1] = (act == mbrm_pkg::ActWrite) ? mbrm_pkg::FuncWrite : mbrm_pkg::FuncRead;
    f[2] = addr[15:8];
    f[3] = addr[7:0];
    f[4] = (act == mbrm_pkg::ActWrite) ? val[15:8] : 8'h00;
    f[5] = (act == mbrm_pkg::ActWrite) ? val[7:0] : 8'h01;
    crc = mbrm_pkg::CrcInit;
    for (int i = 0; i < 6; i++) begin
      crc = crc ^ {8'h00, f[i]};
      for (int k = 0; k < 8; k++)
        crc = crc[0] ? ((crc >> 1) ^ mbrm_pkg::CrcPoly) : (crc >> 1);
    end
    // CRC goes out low byte first.
    f[6] = crc[7:0];
    f[7] = crc[15:8];
    return f;
  endfunction

  function automatic void queue_frame();
    for (int i = 0; i < 8; i++) begin
      expected_words.push_back('{kind: mbrm_pkg::KindTx, tx_byte: pend_frame[i],
                                 last_byte: (i == 7), status: mbrm_pkg::StatusOk,
                                 read_value: 16'h0000});
    end
  endfunction

  function automatic void queue_report(input mbrm_pkg::status_e st, input logic [15:0] v);
    expected_words.push_back('{kind: mbrm_pkg::KindReport, tx_byte: 8'h00, last_byte: 1'b0,
                               status: st, read_value: v});
  endfunction

  function automatic void clear_reply();
    rx_count = 4'd0;
    rx_bad   = 1'b0;
    rx_value = 16'h0000;
  endfunction

  // An attempt limit of zero behaves like one: the first comparison fails.
  function automatic void retry_or_fail();
    clear_reply();
    if (tries < cfg_attempts) begin
      tries = tries + 3'd1;
      queue_frame();
    end else begin
      pend_op = OpIdle;
      queue_report(mbrm_pkg::StatusFail, 16'h0000);
    end
  endfunction

  function automatic void master_step(input in_word_t w);
    if (w.action == mbrm_pkg::ActWrite || w.action == mbrm_pkg::ActRead) begin
      if (pend_op != OpIdle) begin
        queue_report(mbrm_pkg::StatusBusy, 16'h0000);
      end else begin
        pend_frame = build_frame(w.action, w.reg_address, w.reg_value, cfg_slave);
        pend_op    = (w.action == mbrm_pkg::ActWrite) ? OpWrite : OpRead;
        tries      = 3'd1;
        clear_reply();
        queue_frame();
      end
    end else if (pend_op != OpIdle) begin
      if (w.action == mbrm_pkg::ActTimeout) begin
        retry_or_fail();
      end else begin
        if (pend_op == OpWrite) begin
          if (rx_count >= 4'd8 || w.rx_byte != pend_frame[rx_count[2:0]]) rx_bad = 1'b1;
        end else begin
          // The reply id is checked against the id stored in the frame.
          if (rx_count == 4'd0) begin
            if (w.rx_byte != pend_frame[0]) rx_bad = 1'b1;
          end else if (rx_count == 4'd1) begin
            if (w.rx_byte != mbrm_pkg::FuncRead) rx_bad = 1'b1;
          end else if (rx_count == 4'd3) rx_value[15:8] = w.rx_byte;
          else if (rx_count == 4'd4) rx_value[7:0] = w.rx_byte;
          else if (rx_count >= 4'd7) rx_bad = 1'b1;
        end
        if (rx_count != 4'd15) rx_count = rx_count + 4'd1;
        if (w.frame_end) begin
          if (!rx_bad && ((pend_op == OpWrite && rx_count == 4'd8) ||
                          (pend_op == OpRead && rx_count == 4'd7))) begin
            queue_report(mbrm_pkg::StatusOk, rx_value);
            pend_op = OpIdle;
            clear_reply();
          end else begin
            retry_or_fail();
          end
        end
      end
    end
  endfunction

  // Fields that the action does not use get random content.
  function automatic void push_word(input logic [1:0] act, input logic [15:0] addr,
                                    input logic [15:0] val, input logic [7:0] rx,
                                    input logic fend);
    in_word_t w;
    w = '{act, addr, val, rx, fend};
    if (act == mbrm_pkg::ActWrite || act == mbrm_pkg::ActRead) begin
      w.rx_byte   = 8'($urandom);
      w.frame_end = 1'($urandom);
    end else begin
      w.reg_address = 16'($urandom);
      w.reg_value   = 16'($urandom);
      if (act == mbrm_pkg::ActTimeout) begin
        w.rx_byte   = 8'($urandom);
        w.frame_end = 1'($urandom);
      end
    end
    input_words.push_back(w);
    words_pushed++;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_reply(input logic [1:0] op, input mbrm_pkg::frame_t f,
                                     input logic [15:0] value, input fault_e fault);
    logic [7:0]  b[$];
    int unsigned n;
    int unsigned pos;
    if (op == mbrm_pkg::ActWrite) begin
      for (int i = 0; i < 8; i++) b.push_back(f[i]);
    end else begin
      b.push_back(f[0]);
      b.push_back(mbrm_pkg::FuncRead);
      b.push_back(8'h02);
      b.push_back(value[15:8]);
      b.push_back(value[7:0]);
      b.push_back(8'($urandom));
      b.push_back(8'($urandom));
    end
    case (fault)
      FaultCorrupt: begin
        // Only the id and function bytes of a read reply are compared.
        pos = (op == mbrm_pkg::ActWrite) ? $urandom_range(7) : $urandom_range(1);
        b[pos] = b[pos] ^ 8'($urandom_range(1, 255));
      end
      FaultShort: begin
        n = $urandom_range(1, b.size() - 1);
        while (b.size() > n) void'(b.pop_back());
      end
      FaultLong: begin
        repeat ($urandom_range(1, 9)) b.push_back(8'($urandom));
      end
      FaultTimeout: begin
        n = $urandom_range(0, 3);
        while (b.size() > n) void'(b.pop_back());
      end
      default: ;
    endcase
    foreach (b[i]) push_word(mbrm_pkg::ActRxByte, 16'h0000, 16'h0000, b[i],
                             fault != FaultTimeout && i == b.size() - 1);
    if (fault == FaultTimeout)
      push_word(mbrm_pkg::ActTimeout, 16'h0000, 16'h0000, 8'h00, 1'b0);
  endfunction

  // One request and its replies, mostly well formed, ending in success or in
  // failure once the attempt limit is used up.
  function automatic void push_exchange();
    logic [1:0]       op;
    logic [15:0]      addr;
    logic [15:0]      val;
    mbrm_pkg::frame_t f;
    int unsigned      limit;
    if ($urandom_range(19) == 0) begin
      push_word($urandom_range(1) ? mbrm_pkg::ActRxByte : mbrm_pkg::ActTimeout,
                16'h0000, 16'h0000, 8'($urandom), 1'($urandom));
      noise_pushed++;
    end
    op   = $urandom_range(1) ? mbrm_pkg::ActRead : mbrm_pkg::ActWrite;
    addr = pick_word();
    val  = pick_word();
    f    = build_frame(op, addr, val, cfg_slave);
    push_word(op, addr, val, 8'h00, 1'b0);
    limit = (cfg_attempts == 3'd0) ? 1 : cfg_attempts;
    for (int n = 1; n <= limit; n++) begin
      if ($urandom_range(9) == 0)
        push_word($urandom_range(1) ? mbrm_pkg::ActRead : mbrm_pkg::ActWrite,
                  pick_word(), pick_word(), 8'h00, 1'b0);
      if ($urandom_range(99) < 55) begin
        push_reply(op, f, pick_word(), FaultNone);
        break;
      end
      push_reply(op, f, pick_word(), fault_e'($urandom_range(1, 4)));
    end
  endfunction

  task automatic wait_idle();
    while (words_taken != words_pushed || expected_words.size() != 0) @(posedge clk_i);
    // Reply bytes before a frame end cause no output, so allow for them too.
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == mbrm_pkg::CfgSlaveId) cfg_slave = data;
    else cfg_attempts = data[2:0];
    n_reg_writes++;
  endtask

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    errors++;
  endtask

  // Input driver: a word stays on the port until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        master_step(cur_word);
        words_taken++;
        case (cur_word.action)
          mbrm_pkg::ActRxByte:  n_rx_bytes++;
          mbrm_pkg::ActTimeout: n_timeouts++;
          default:              n_requests++;
        endcase
      end
      if (!in_valid_i || in_ready_o) begin
        if (input_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_word      = input_words.pop_front();
          in_valid_i    <= 1'b1;
          action_i      <= cur_word.action;
          reg_address_i <= cur_word.reg_address;
          reg_value_i   <= cur_word.reg_value;
          rx_byte_i     <= cur_word.rx_byte;
          frame_end_i   <= cur_word.frame_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word: kind %0d tx_byte 0x%0h status %0d",
                 kind_o, tx_byte_o, status_o);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (kind_o !== want.kind) report_field("kind", want.kind, kind_o);
          if (tx_byte_o !== want.tx_byte) report_field("tx_byte", want.tx_byte, tx_byte_o);
          if (last_byte_o !== want.last_byte)
            report_field("last_byte", want.last_byte, last_byte_o);
          if (status_o !== want.status) report_field("status", want.status, status_o);
          if (read_value_o !== want.read_value)
            report_field("read_value", want.read_value, read_value_o);
          if (want.kind == mbrm_pkg::KindTx) n_tx_words++;
          else if (want.status == mbrm_pkg::StatusOk) n_ok++;
          else if (want.status == mbrm_pkg::StatusFail) n_failed++;
          else n_busy++;
        end
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o === 1'b1 && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WatchdogLimit) begin
      $display("Timeout: no word moved for %0d cycles", WatchdogLimit);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    mbrm_pkg::frame_t f;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset configuration.
    push_word(mbrm_pkg::ActRxByte, 16'h0000, 16'h0000, 8'hFF, 1'b1);
    push_word(mbrm_pkg::ActTimeout, 16'h0000, 16'h0000, 8'h00, 1'b0);
    f = build_frame(mbrm_pkg::ActWrite, 16'hFFFF, 16'h0000, ResetSlaveId);
    push_word(mbrm_pkg::ActWrite, 16'hFFFF, 16'h0000, 8'h00, 1'b0);
    push_word(mbrm_pkg::ActRead, 16'h1234, 16'h0000, 8'h00, 1'b0);
    push_word(mbrm_pkg::ActTimeout, 16'h0000, 16'h0000, 8'h00, 1'b0);
    push_reply(mbrm_pkg::ActWrite, f, 16'h0000, FaultNone);
    push_word(mbrm_pkg::ActRead, 16'h0000, 16'hFFFF, 8'h00, 1'b0);
    push_word(mbrm_pkg::ActWrite, 16'h5A5A, 16'hA5A5, 8'h00, 1'b0);
    repeat (3) push_word(mbrm_pkg::ActTimeout, 16'h0000, 16'h0000, 8'h00, 1'b0);
    f = build_frame(mbrm_pkg::ActRead, 16'h8001, 16'h0000, ResetSlaveId);
    push_word(mbrm_pkg::ActRead, 16'h8001, 16'h0000, 8'h00, 1'b0);
    push_reply(mbrm_pkg::ActRead, f, 16'h80FF, FaultNone);

    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(mbrm_pkg::CfgSlaveId, 8'h00);
          write_reg(mbrm_pkg::CfgMaxAttempts, 8'd7);
        end
        1: begin
          write_reg(mbrm_pkg::CfgSlaveId, 8'hFF);
          write_reg(mbrm_pkg::CfgMaxAttempts, 8'd1);
        end
        2: begin
          tx_idle_pct = 69;
          rx_idle_pct = 8;
          write_reg(mbrm_pkg::CfgSlaveId, 8'($urandom));
          write_reg(mbrm_pkg::CfgMaxAttempts, 8'd0);
        end
        3: begin
          write_reg(mbrm_pkg::CfgSlaveId, 8'($urandom));
          write_reg(mbrm_pkg::CfgMaxAttempts, 8'($urandom_range(2, 6)));
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_reg(mbrm_pkg::CfgSlaveId, 8'($urandom));
          write_reg(mbrm_pkg::CfgMaxAttempts, 8'(ResetAttempts));
        end
      endcase
      while (words_pushed - noise_pushed < words_taken + ((ph == 4) ? 60 : 45))
        push_exchange();
    end

    for (int w = 0; w < EndWaitLimit &&
         (words_taken != words_pushed || expected_words.size() != 0); w++) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("%0d expected output words never arrived", expected_words.size());
      errors++;
    end

    $display("Summary: %0d requests, %0d reply bytes, %0d timeouts, %0d register writes",
             n_requests, n_rx_bytes, n_timeouts, n_reg_writes);
    $display("Summary: %0d frame bytes sent, reports: %0d ok, %0d failed, %0d refused busy",
             n_tx_words, n_ok, n_failed, n_busy);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* modbus_rtu_register_master_top.f */
rtl/core/mbrm_pkg.sv
rtl/core/mbrm_front.sv
rtl/core/mbrm_queue.sv
rtl/core/mbrm_back.sv
rtl/core/modbus_rtu_register_master_top.sv
tb/sv/testbench.sv
